/* design/dsfr_pkg.sv */
`default_nettype none

package dsfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int VALUE_W         = 16;
    localparam int STATUS_W        = 2;
    localparam int IDX_W           = 5;
    localparam int NUM_VALUES      = 3;
    localparam int FRAME_BYTES_DEF = 23;

    // Start and header bytes of the two frame formats.
    localparam logic [BYTE_W-1:0] START_CONT  = 8'h42;
    localparam logic [BYTE_W-1:0] HEAD_CONT   = 8'h4D;
    localparam logic [BYTE_W-1:0] START_QUERY = 8'hFF;
    localparam logic [BYTE_W-1:0] HEAD_QUERY  = 8'h86;

    // Index of the last byte of a query reply, counting the start byte as 0.
    localparam logic [IDX_W-1:0] QUERY_LAST_IDX = 5'd8;
    localparam logic [IDX_W-1:0] QUERY_HEAD_IDX = 5'd1;
    localparam logic [IDX_W-1:0] CONT_HEAD_IDX  = 5'd0;
    localparam logic [IDX_W-1:0] FIRST_READ_IDX = 5'd2;
    localparam logic [IDX_W-1:0] LAST_READ_IDX  = 5'd7;

    // Frame status codes.
    localparam logic [STATUS_W-1:0] ST_GOOD   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CKSUM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HEADER = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } dsfr_byte_t;

    typedef struct packed {
        logic [STATUS_W-1:0] frame_status;
        logic [VALUE_W-1:0]  pm1_reading;
        logic [VALUE_W-1:0]  pm25_reading;
        logic [VALUE_W-1:0]  pm10_reading;
    } dsfr_result_t;

endpackage

`default_nettype wire

/* design/dsfr_if.sv */
`default_nettype none

// Byte channel from the serial receiver.
interface dsfr_byte_if;
    logic                        valid;
    logic                        ready;
    logic [dsfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel, one beat per completed frame.
interface dsfr_result_if;
    logic                          valid;
    logic                          ready;
    logic [dsfr_pkg::STATUS_W-1:0] frame_status;
    logic [dsfr_pkg::VALUE_W-1:0]  pm1_reading;
    logic [dsfr_pkg::VALUE_W-1:0]  pm25_reading;
    logic [dsfr_pkg::VALUE_W-1:0]  pm10_reading;

    modport source (output valid, output frame_status, output pm1_reading,
                    output pm25_reading, output pm10_reading, input ready);
    modport sink   (input valid, input frame_status, input pm1_reading,
                    input pm25_reading, input pm10_reading, output ready);
endinterface

`default_nettype wire

/* design/dsfr_in_stage.sv */
`default_nettype none

module dsfr_in_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [dsfr_pkg::BYTE_W-1:0] in_data,
    output logic                             in_ready,
    input  wire logic                        take,
    output dsfr_pkg::dsfr_byte_t             stage
);
    import dsfr_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;

    // The held byte leaves whenever the parser takes it, so a new one may
    // enter in the same cycle.
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

`default_nettype wire

/* design/dsfr_parser.sv */
`default_nettype none

module dsfr_parser #(
    parameter int FRAME_BYTES = dsfr_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,
    input  wire dsfr_pkg::dsfr_byte_t stage,
    input  wire logic                 take,
    output logic                      res_valid,
    output dsfr_pkg::dsfr_result_t    res
);
    import dsfr_pkg::*;

    localparam logic [IDX_W-1:0] CONT_CKHI_IDX = IDX_W'(FRAME_BYTES - 2);
    localparam logic [IDX_W-1:0] CONT_LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    logic               mode_reg,       mode_next;
    logic               collecting_reg, collecting_next;
    logic [IDX_W-1:0]   idx_reg,        idx_next;
    logic [VALUE_W-1:0] sum_reg,        sum_next;
    logic               hdr_ok_reg,     hdr_ok_next;
    logic [BYTE_W-1:0]  cks_hi_reg,     cks_hi_next;
    logic [VALUE_W-1:0] pend_reg [NUM_VALUES];
    logic [VALUE_W-1:0] pend_next [NUM_VALUES];
    logic [VALUE_W-1:0] held_reg [NUM_VALUES];
    logic [VALUE_W-1:0] held_next [NUM_VALUES];

    logic [BYTE_W-1:0]   b;
    logic [IDX_W-1:0]    rd_off;
    logic [1:0]          rd_k;
    logic                is_last;
    logic                hdr_now;
    logic                sum_ok;
    logic [BYTE_W-1:0]   q_expect;
    logic [STATUS_W-1:0] status;

    assign b        = stage.data;
    assign rd_off   = idx_reg - FIRST_READ_IDX;
    assign rd_k     = rd_off[2:1];
    assign q_expect = BYTE_W'(0) - sum_reg[BYTE_W-1:0];

    assign is_last = collecting_reg &&
                     (mode_reg ? (idx_reg == QUERY_LAST_IDX) : (idx_reg == CONT_LAST_IDX));

    always_comb
    begin
        hdr_now = hdr_ok_reg;
        if (!mode_reg && idx_reg == CONT_HEAD_IDX)
        begin
            hdr_now = (b == HEAD_CONT);
        end
        else if (mode_reg && idx_reg == QUERY_HEAD_IDX)
        begin
            hdr_now = (b == HEAD_QUERY);
        end
    end

    assign sum_ok = mode_reg ? (q_expect == b) : ({cks_hi_reg, b} == sum_reg);

    always_comb
    begin
        if (!hdr_now)
        begin
            status = ST_HEADER;
        end
        else if (!sum_ok)
        begin
            status = ST_CKSUM;
        end
        else
        begin
            status = ST_GOOD;
        end
    end

    // Pending readings pick up frame bytes 2 to 7, high byte first.
    always_comb
    begin
        for (int k = 0; k < NUM_VALUES; k++)
        begin
            pend_next[k] = pend_reg[k];
        end
        if (stage.valid && collecting_reg &&
            idx_reg >= FIRST_READ_IDX && idx_reg <= LAST_READ_IDX)
        begin
            if (!idx_reg[0])
            begin
                pend_next[rd_k] = {b, BYTE_W'(0)};
            end
            else
            begin
                pend_next[rd_k] = {pend_reg[rd_k][VALUE_W-1:BYTE_W], b};
            end
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        collecting_next = collecting_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        hdr_ok_next     = hdr_ok_reg;
        cks_hi_next     = cks_hi_reg;
        for (int k = 0; k < NUM_VALUES; k++)
        begin
            held_next[k] = held_reg[k];
        end

        if (cfg_wr_en)
        begin
            mode_next       = cfg_wr_data;
            collecting_next = 1'b0;
            idx_next        = '0;
            sum_next        = '0;
            hdr_ok_next     = 1'b0;
            cks_hi_next     = '0;
        end
        else if (take)
        begin
            if (!collecting_reg)
            begin
                if (!mode_reg && b == START_CONT)
                begin
                    collecting_next = 1'b1;
                    idx_next        = CONT_HEAD_IDX;
                    sum_next        = VALUE_W'(START_CONT);
                end
                else if (mode_reg && b == START_QUERY)
                begin
                    collecting_next = 1'b1;
                    idx_next        = QUERY_HEAD_IDX;
                    sum_next        = '0;
                end
            end
            else if (is_last)
            begin
                if (status == ST_GOOD)
                begin
                    for (int k = 0; k < NUM_VALUES; k++)
                    begin
                        held_next[k] = pend_next[k];
                    end
                end
                collecting_next = 1'b0;
                idx_next        = '0;
                sum_next        = '0;
                hdr_ok_next     = 1'b0;
                cks_hi_next     = '0;
            end
            else
            begin
                hdr_ok_next = hdr_now;
                idx_next    = idx_reg + IDX_W'(1);
                if (!mode_reg && idx_reg == CONT_CKHI_IDX)
                begin
                    cks_hi_next = b;
                end
                else
                begin
                    sum_next = sum_reg + VALUE_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            collecting_reg <= 1'b0;
            idx_reg        <= '0;
            sum_reg        <= '0;
            hdr_ok_reg     <= 1'b0;
            cks_hi_reg     <= '0;
            for (int k = 0; k < NUM_VALUES; k++)
            begin
                held_reg[k] <= '0;
            end
        end
        else
        begin
            mode_reg       <= mode_next;
            collecting_reg <= collecting_next;
            idx_reg        <= idx_next;
            sum_reg        <= sum_next;
            hdr_ok_reg     <= hdr_ok_next;
            cks_hi_reg     <= cks_hi_next;
            for (int k = 0; k < NUM_VALUES; k++)
            begin
                held_reg[k] <= held_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int k = 0; k < NUM_VALUES; k++)
            begin
                pend_reg[k] <= pend_next[k];
            end
        end
    end

    assign res_valid        = stage.valid && is_last;
    assign res.frame_status = status;
    assign res.pm1_reading  = (status == ST_GOOD) ? pend_next[0] : held_reg[0];
    assign res.pm25_reading = (status == ST_GOOD) ? pend_next[1] : held_reg[1];
    assign res.pm10_reading = (status == ST_GOOD) ? pend_next[2] : held_reg[2];

endmodule

`default_nettype wire

/* design/dsfr_out_stage.sv */
`default_nettype none

module dsfr_out_stage (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire dsfr_pkg::dsfr_result_t load_data,
    output logic                        free,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output dsfr_pkg::dsfr_result_t      out_data
);
    import dsfr_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    dsfr_result_t data_reg;

    // The slot may be refilled in the cycle in which its beat is taken.
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* design/dust_sensor_frame_receiver_unit.sv */
`default_nettype none

// Particulate sensor frame receiver. Bytes from the sensor's serial line
// arrive on the rx channel, one byte per beat, and the block emits one
// beat on the result channel for every complete frame: a status (good,
// checksum mismatch, or wrong header/command byte) together with the PM1.0,
// PM2.5 and PM10 readings held after that frame, which change only on a good
// frame. With query_mode clear the block hunts for 0x42 and collects
// FRAME_BYTES further bytes, checking a 16-bit sum; with query_mode set it
// collects a 9-byte reply that starts at 0xFF and checks an 8-bit negated
// sum. Writing query_mode drops any partial frame. A byte may be accepted in
// every cycle: each byte is registered on entry and handled by the parser
// once it is taken from that register. If it ends a frame, the frame's beat
// is written into the result register at the end of that same cycle, and
// the result is offered from that register. The input side stalls only
// when the byte held on entry ends a frame while the result register is
// occupied and its beat is not being taken.
module dust_sensor_frame_receiver_unit #(
    parameter int FRAME_BYTES = dsfr_pkg::FRAME_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_wr_en,
    input  wire logic           cfg_wr_data,
    dsfr_byte_if.sink           rx,
    dsfr_result_if.source       result
);
    import dsfr_pkg::*;

    dsfr_byte_t   stage;
    dsfr_result_t res;
    dsfr_result_t out_data;
    logic         res_valid;
    logic         take;
    logic         out_free;

    // The held byte is processed when it either ends no frame or the result
    // register has room for the frame's beat.
    assign take = stage.valid && (!res_valid || out_free);

    dsfr_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_data  (rx.rx_byte),
        .in_ready (rx.ready),
        .take     (take),
        .stage    (stage)
    );

    dsfr_parser #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stage       (stage),
        .take        (take),
        .res_valid   (res_valid),
        .res         (res)
    );

    dsfr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .load_data (res),
        .free      (out_free),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    // The result register drives the channel payload directly.
    assign result.frame_status = out_data.frame_status;
    assign result.pm1_reading  = out_data.pm1_reading;
    assign result.pm25_reading = out_data.pm25_reading;
    assign result.pm10_reading = out_data.pm10_reading;

endmodule

`default_nettype wire

/* design/dsfr_checker.sv */
`default_nettype none

module dsfr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          rx_ready,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic [dsfr_pkg::STATUS_W-1:0] frame_status,
    input wire logic [dsfr_pkg::VALUE_W-1:0]  pm1_reading,
    input wire logic [dsfr_pkg::VALUE_W-1:0]  pm25_reading,
    input wire logic [dsfr_pkg::VALUE_W-1:0]  pm10_reading
);
    import dsfr_pkg::*;

    // Readings of the last delivered beat, which are the held readings.
    logic [VALUE_W-1:0] seen_reg [NUM_VALUES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_VALUES; k++)
            begin
                seen_reg[k] <= '0;
            end
        end
        else if (res_valid && res_ready)
        begin
            seen_reg[0] <= pm1_reading;
            seen_reg[1] <= pm25_reading;
            seen_reg[2] <= pm10_reading;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(frame_status) &&
        $stable(pm1_reading) && $stable(pm25_reading) && $stable(pm10_reading))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> frame_status == ST_GOOD || frame_status == ST_CKSUM ||
        frame_status == ST_HEADER)
        else $error("undefined frame status");

    a_bad_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_status != ST_GOOD |-> pm1_reading == seen_reg[0] &&
        pm25_reading == seen_reg[1] && pm10_reading == seen_reg[2])
        else $error("readings changed on a failed frame");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> rx_ready)
        else $error("input stalled with the result register empty");

endmodule

bind dust_sensor_frame_receiver_unit dsfr_checker u_dsfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_ready     (rx.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .frame_status (result.frame_status),
    .pm1_reading  (result.pm1_reading),
    .pm25_reading (result.pm25_reading),
    .pm10_reading (result.pm10_reading)
);

`default_nettype wire

/* test/dust_sensor_frame_receiver_unit_test.sv */
`timescale 1ns / 100ps

// Self-checking bench for the particulate sensor frame receiver. Bytes are
// pushed through the rx channel one beat at a time; a local model of the
// framing logic follows every accepted beat and queues the frame report it
// expects. Each report beat taken from the block is compared field by field
// with the oldest queued report.
module dust_sensor_frame_receiver_unit_test;

    import dsfr_pkg::*;

    // The block is built with its default frame length.
    localparam int FRAME_LEN     = FRAME_BYTES_DEF;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int PHASE_ITEMS   = RANDOM_ITEMS / 6;
    // Quiet cycles allowed for the pipeline to empty before a mode write.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 400000;

    // One directed frame. A non-zero cut sends only that many bytes, leaving
    // a partial frame behind. Where typed is set, want holds the report that
    // the frame must produce; otherwise the local model supplies it.
    typedef struct packed {
        logic         mode;
        logic         reload;
        logic [7:0]   head;
        logic [15:0]  pm1;
        logic [15:0]  pm25;
        logic [15:0]  pm10;
        logic [7:0]   fill;
        logic         spoil;
        logic [4:0]   cut;
        logic         typed;
        dsfr_result_t want;
    } frame_row_t;

    localparam dsfr_result_t NO_WANT = '0;

    localparam frame_row_t SCRIPT [0:12] = '{
        // Continuous mode straight after reset, all filler bytes at 0xFF so
        // that the 16-bit sum runs high.
        '{1'b0, 1'b0, HEAD_CONT, 16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF, 1'b0, 5'd0,
          1'b1, '{ST_GOOD, 16'hFFFF, 16'h0000, 16'hFFFF}},
        // Wrong header byte: the readings must not move.
        '{1'b0, 1'b0, 8'h4C, 16'h1111, 16'h2222, 16'h3333, 8'h00, 1'b0, 5'd0,
          1'b1, '{ST_HEADER, 16'hFFFF, 16'h0000, 16'hFFFF}},
        // Checksum off by one.
        '{1'b0, 1'b0, HEAD_CONT, 16'h1111, 16'h2222, 16'h3333, 8'h00, 1'b1, 5'd0,
          1'b1, '{ST_CKSUM, 16'hFFFF, 16'h0000, 16'hFFFF}},
        // Both faults at once: the header fault wins.
        '{1'b0, 1'b0, 8'h00, 16'h1111, 16'h2222, 16'h3333, 8'h00, 1'b1, 5'd0,
          1'b1, '{ST_HEADER, 16'hFFFF, 16'h0000, 16'hFFFF}},
        // Start bytes inside the frame are plain data.
        '{1'b0, 1'b0, HEAD_CONT, 16'h4242, 16'h4242, 16'h4242, 8'h42, 1'b0, 5'd0,
          1'b0, NO_WANT},
        // A partial frame, dropped by rewriting the same mode.
        '{1'b0, 1'b0, HEAD_CONT, 16'hABCD, 16'hABCD, 16'hABCD, 8'h00, 1'b0, 5'd9,
          1'b0, NO_WANT},
        '{1'b0, 1'b1, HEAD_CONT, 16'h0001, 16'h0100, 16'h8000, 8'h00, 1'b0, 5'd0,
          1'b1, '{ST_GOOD, 16'h0001, 16'h0100, 16'h8000}},
        // Query replies.
        '{1'b1, 1'b1, HEAD_QUERY, 16'h0000, 16'hFFFF, 16'h0000, 8'h00, 1'b0, 5'd0,
          1'b1, '{ST_GOOD, 16'h0000, 16'hFFFF, 16'h0000}},
        '{1'b1, 1'b0, 8'h87, 16'h1234, 16'h5678, 16'h9ABC, 8'h00, 1'b0, 5'd0,
          1'b1, '{ST_HEADER, 16'h0000, 16'hFFFF, 16'h0000}},
        '{1'b1, 1'b0, HEAD_QUERY, 16'h1234, 16'h5678, 16'h9ABC, 8'h00, 1'b1, 5'd0,
          1'b1, '{ST_CKSUM, 16'h0000, 16'hFFFF, 16'h0000}},
        // 0xFF inside a reply is data, not a new start.
        '{1'b1, 1'b0, HEAD_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0, 5'd0,
          1'b0, NO_WANT},
        // A partial reply, dropped by the switch back to continuous mode.
        '{1'b1, 1'b0, HEAD_QUERY, 16'h5555, 16'hAAAA, 16'h5555, 8'h00, 1'b0, 5'd4,
          1'b0, NO_WANT},
        '{1'b0, 1'b1, HEAD_CONT, 16'h1357, 16'h2468, 16'h7F80, 8'h00, 1'b0, 5'd0,
          1'b0, NO_WANT}
    };

    // Idling profiles, in percent: sender gaps and receiver stalls.
    localparam int TX_IDLE [0:2] = '{7, 45, 0};
    localparam int RX_STALL [0:2] = '{45, 7, 0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en;
    logic cfg_wr_data;

    dsfr_byte_if   rx_bus ();
    dsfr_result_if report_bus ();

    dust_sensor_frame_receiver_unit #(
        .FRAME_BYTES (FRAME_LEN)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx          (rx_bus),
        .result      (report_bus)
    );

    always #2 clk = ~clk;

    // Local copy of the framing state.
    logic        q_mode;
    logic        in_frame;
    logic [4:0]  frame_pos;
    logic [15:0] frame_sum;
    logic        head_good;
    logic [15:0] sum_field;
    logic [15:0] staged_pm [3];
    logic [15:0] shown_pm [3];

    // Reports still owed by the block, oldest first.
    dsfr_result_t frame_reports_due [$];
    // Bytes of the frame being composed for sending.
    logic [7:0]   frame_buf [$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_asked = 0;
    int hold_given = 0;
    int hold_left = 0;
    int mismatches = 0;
    int bytes_taken = 0;
    int status_tally [4] = '{0, 0, 0, 0};
    int cycle_count = 0;

    // Back to hunting for a start byte; the held readings survive.
    function automatic void drop_frame();
        in_frame  = 1'b0;
        frame_pos = '0;
        frame_sum = '0;
        head_good = 1'b0;
        sum_field = '0;
    endfunction

    // Called on the last byte of a frame. Only a good frame copies the staged
    // readings into the held ones; every frame yields one report.
    function automatic void close_frame(input logic sum_ok);
        dsfr_result_t rep;
        if (!head_good)
        begin
            rep.frame_status = ST_HEADER;
        end
        else if (!sum_ok)
        begin
            rep.frame_status = ST_CKSUM;
        end
        else
        begin
            rep.frame_status = ST_GOOD;
            shown_pm = staged_pm;
        end
        rep.pm1_reading  = shown_pm[0];
        rep.pm25_reading = shown_pm[1];
        rep.pm10_reading = shown_pm[2];
        frame_reports_due.push_back(rep);
        drop_frame();
    endfunction

    // Follows one accepted byte through the framing rules.
    function automatic void parse_rx_byte(input logic [7:0] b);
        int          k;
        logic [7:0]  neg_sum;
        if (!in_frame)
        begin
            if (!q_mode && b == START_CONT)
            begin
                in_frame  = 1'b1;
                frame_pos = '0;
                frame_sum = 16'(START_CONT);
            end
            else if (q_mode && b == START_QUERY)
            begin
                in_frame  = 1'b1;
                frame_pos = QUERY_HEAD_IDX;
                frame_sum = '0;
            end
            return;
        end

        if (frame_pos == (q_mode ? QUERY_HEAD_IDX : CONT_HEAD_IDX))
            head_good = (b == (q_mode ? HEAD_QUERY : HEAD_CONT));

        // Readings sit big-endian at positions two to seven in both modes.
        if (frame_pos >= FIRST_READ_IDX && frame_pos <= LAST_READ_IDX)
        begin
            k = (int'(frame_pos) - 2) / 2;
            if (!frame_pos[0])
                staged_pm[k] = {b, 8'h00};
            else
                staged_pm[k] = staged_pm[k] | {8'h00, b};
        end

        if (!q_mode)
        begin
            if (int'(frame_pos) + 2 < FRAME_LEN)
            begin
                frame_sum = frame_sum + 16'(b);
            end
            else if (int'(frame_pos) + 2 == FRAME_LEN)
            begin
                sum_field = {b, 8'h00};
            end
            else
            begin
                sum_field = sum_field | {8'h00, b};
                close_frame(sum_field == frame_sum);
                return;
            end
        end
        else
        begin
            if (frame_pos < QUERY_LAST_IDX)
            begin
                frame_sum = frame_sum + 16'(b);
            end
            else
            begin
                neg_sum   = ~frame_sum[7:0] + 8'd1;
                sum_field = 16'(b);
                close_frame(neg_sum == b);
                return;
            end
        end
        frame_pos = frame_pos + 5'd1;
    endfunction

    // Builds a frame in frame_buf. A spoilt frame has the lowest bit of its
    // checksum flipped. Filler bytes are either the given value or random.
    function automatic void compose_frame(input logic m, input logic [7:0] head,
                                          input logic [15:0] v1, input logic [15:0] v25,
                                          input logic [15:0] v10, input logic [7:0] fill,
                                          input logic rand_fill, input logic spoil);
        logic [15:0] vals [3];
        logic [15:0] sum;
        logic [7:0]  b;
        int          first;
        int          last;
        int          p;
        vals[0] = v1;
        vals[1] = v25;
        vals[2] = v10;
        first = m ? 1 : 0;
        last  = m ? int'(QUERY_LAST_IDX) - 1 : FRAME_LEN - 3;
        frame_buf.delete();
        frame_buf.push_back(m ? START_QUERY : START_CONT);
        sum = m ? 16'h0000 : 16'(START_CONT);
        for (p = first; p <= last; p++)
        begin
            if (p == first)
                b = head;
            else if (p >= 2 && p <= 7)
                b = (p % 2 == 0) ? vals[(p - 2) / 2][15:8] : vals[(p - 2) / 2][7:0];
            else
                b = rand_fill ? 8'($urandom) : fill;
            frame_buf.push_back(b);
            sum = sum + 16'(b);
        end
        if (m)
        begin
            frame_buf.push_back((~sum[7:0] + 8'd1) ^ {7'd0, spoil});
        end
        else
        begin
            sum = sum ^ {15'd0, spoil};
            frame_buf.push_back(sum[15:8]);
            frame_buf.push_back(sum[7:0]);
        end
    endfunction

    // Offers one byte, with random gaps first, and holds it until accepted.
    // Valid is left high so that the next byte can follow without a gap.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            rx_bus.valid <= 1'b0;
            @(posedge clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        do
            @(posedge clk);
        while (rx_bus.ready !== 1'b1);
        bytes_taken++;
        parse_rx_byte(b);
    endtask

    task automatic send_frame(input int n);
        int j;
        for (j = 0; j < n; j++)
            send_byte(frame_buf[j]);
    endtask

    // The mode register is only touched once every owed report has come out
    // and the pipeline has had time to empty, since a partial frame leaves no
    // report behind to wait for.
    task automatic set_query_mode(input logic m);
        rx_bus.valid <= 1'b0;
        while (frame_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        q_mode = m;
        drop_frame();
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Report side: takes beats, compares them, and drives ready. A long
    // hold-off, once asked for by the stimulus, is counted out here while the
    // sender keeps pushing bytes, so the block backs up into its input.
    always @(posedge clk)
    begin
        dsfr_result_t want;
        if (report_bus.valid === 1'b1 && report_bus.ready === 1'b1)
        begin
            status_tally[report_bus.frame_status]++;
            if (frame_reports_due.size() == 0)
            begin
                $error("frame report beat with no report expected");
                mismatches++;
            end
            else
            begin
                want = frame_reports_due.pop_front();
                check_field("frame_status", 16'(want.frame_status),
                            16'(report_bus.frame_status));
                check_field("pm1_reading", want.pm1_reading, report_bus.pm1_reading);
                check_field("pm25_reading", want.pm25_reading, report_bus.pm25_reading);
                check_field("pm10_reading", want.pm10_reading, report_bus.pm10_reading);
            end
        end

        if (hold_asked != hold_given)
        begin
            hold_given        <= hold_asked;
            hold_left         <= LONG_HOLD;
            report_bus.ready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left         <= hold_left - 1;
            report_bus.ready  <= 1'b0;
        end
        else
        begin
            report_bus.ready  <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        frame_row_t  row;
        logic [15:0] rv [3];
        logic [7:0]  head;
        int          r;
        int          pf;
        int          md;
        int          k;
        int          n;
        int          pick;
        int          sent;

        rx_bus.valid     <= 1'b0;
        rx_bus.rx_byte   <= '0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= 1'b0;

        q_mode = 1'b0;
        drop_frame();
        for (k = 0; k < 3; k++)
        begin
            staged_pm[k] = '0;
            shown_pm[k]  = '0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames run under the first idling profile.
        tx_idle_pct = TX_IDLE[0];
        rx_stall_pct <= RX_STALL[0];
        for (r = 0; r < $size(SCRIPT); r++)
        begin
            row = SCRIPT[r];
            if (row.reload)
                set_query_mode(row.mode);
            compose_frame(row.mode, row.head, row.pm1, row.pm25, row.pm10,
                          row.fill, 1'b0, row.spoil);
            send_frame(row.cut != 0 ? int'(row.cut) : frame_buf.size());
            // The last beat was only just taken, so its report is still queued.
            if (row.typed)
                frame_reports_due[frame_reports_due.size() - 1] = row.want;
        end

        // Random part: each idling profile in both modes. Most of it is well
        // formed frames with random readings and filler; the rest is line
        // noise, corrupted headers or checksums, and frames cut short.
        for (pf = 0; pf < 3; pf++)
        begin
            for (md = 0; md < 2; md++)
            begin
                tx_idle_pct = TX_IDLE[pf];
                rx_stall_pct <= RX_STALL[pf];
                set_query_mode(1'(md));
                if (pf == 2 && md == 1)
                    hold_asked <= hold_asked + 1;
                sent = 0;
                while (sent < PHASE_ITEMS)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 10)
                    begin
                        n = $urandom_range(1, 6);
                        repeat (n) send_byte(8'($urandom));
                        sent += n;
                    end
                    else
                    begin
                        for (k = 0; k < 3; k++)
                        begin
                            case ($urandom_range(0, 7))
                                0:       rv[k] = 16'h0000;
                                1:       rv[k] = 16'hFFFF;
                                default: rv[k] = 16'($urandom);
                            endcase
                        end
                        head = (pick < 20) ? 8'($urandom) : (md != 0 ? HEAD_QUERY : HEAD_CONT);
                        compose_frame(1'(md), head, rv[0], rv[1], rv[2], 8'h00, 1'b1,
                                      pick >= 20 && pick < 30);
                        n = (pick >= 90) ? $urandom_range(1, frame_buf.size() - 1)
                                         : frame_buf.size();
                        send_frame(n);
                        sent += n;
                    end
                end
            end
        end

        rx_bus.valid <= 1'b0;
        while (frame_reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes through both framing modes under three idling profiles,",
                 bytes_taken);
        $display("with one long report hold-off; reports: %0d good, %0d bad sum, %0d bad header.",
                 status_tally[ST_GOOD], status_tally[ST_CKSUM], status_tally[ST_HEADER]);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
design/dsfr_pkg.sv
design/dsfr_if.sv
design/dsfr_in_stage.sv
design/dsfr_parser.sv
design/dsfr_out_stage.sv
design/dust_sensor_frame_receiver_unit.sv
design/dsfr_checker.sv
test/dust_sensor_frame_receiver_unit_test.sv
